@@ sv/atb_pkg.sv @@
// atb_pkg: shared types and codes of the alias table builder
// used by atb_ctrl, atb_datapath and alias_table_builder; no dependencies
package atb_pkg;

    localparam int MASS_W   = 33;
    localparam int INDEX_W  = 10;
    localparam int CNT_W    = 11;
    localparam int ERR_W    = 2;
    localparam int IN_DW    = 48;
    localparam int OUT_DW   = 56;

    // request kinds on the input side
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // result error codes
    localparam logic [ERR_W-1:0] ERR_OK  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVF = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD = 2'd2;

    // scaled store read address select
    localparam logic [1:0] SC_SEL_SCAN  = 2'd0;
    localparam logic [1:0] SC_SEL_SMALL = 2'd1;
    localparam logic [1:0] SC_SEL_G     = 2'd2;

    // 1.0 in Q1.32 at mass width
    localparam logic [MASS_W-1:0] PROB_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       rd_req;
        logic       scan_mul;
        logic       scan_wr;
        logic       pop_pair;
        logic       cap_pair;
        logic       cap_sl;
        logic       upd_pair;
        logic       lg_pop;
        logic       lg_wr;
        logic       sm_pop;
        logic       sm_wr;
        logic       rep_build;
        logic       rep_read;
        logic [1:0] sc_rsel;
        logic       pr_rsel;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic sd_nz;
        logic ld_nz;
        logic out_free;
    } t_stat;

endpackage

@@ sv/alias_table_builder.sv @@
// alias_table_builder: top level of the alias table builder
// depends on atb_pkg, atb_ctrl and atb_datapath
//
// Builds an alias table by Vose's method from streamed bin masses in Q1.32.
// The load flagged tlast starts the build, during which no request is
// accepted. The build scales the N masses (read, multiply, write back and
// push), runs the pairing steps (pop, read small, read large, update; at
// most N-1 steps), then writes each leftover bin (pop, write); the
// one-bin-at-a-time walk over registered-read stores sets its length. A
// read registers its index and the table read, and its result then sits in
// the output register once that is free; the build report follows the
// build. The input is accepted again while a result waits to be taken. The
// stores hold MAX_BINS entries and need no clearing after reset.
module alias_table_builder #(
    parameter int MAX_BINS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // mass[32:0], index[42:33], zero pad
    input  logic        i_s_axis_tuser,   // action
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // prob[32:0], alias_res[42:33],
                                          // bin_count[53:43], error[55:54]
    output logic        o_m_axis_tuser    // kind
);
    import atb_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_valid;

    // the controller sees a request only when one is offered
    assign in_valid = i_s_axis_tvalid;

    atb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_action(i_s_axis_tuser),
        .i_last  (i_s_axis_tlast),
        .i_stat  (stat),
        .o_ready (o_s_axis_tready),
        .o_cmd   (cmd)
    );

    atb_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_mass     (i_s_axis_tdata[MASS_W-1:0]),
        .i_index    (i_s_axis_tdata[MASS_W+INDEX_W-1:MASS_W]),
        .o_valid    (o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_kind     (o_m_axis_tuser)
    );

endmodule

@@ sv/atb_ram.sv @@
// atb_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module atb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [Aw-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [Aw-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/atb_ctrl.sv @@
// atb_ctrl: sequencer for load, scan, pairing, leftover, report and read steps
// depends on atb_pkg
module atb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_action,
    input  logic          i_last,
    input  atb_pkg::t_stat i_stat,
    output logic          o_ready,
    output atb_pkg::t_cmd o_cmd
);
    import atb_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_MUL = 4'd2;
    localparam logic [3:0] S_SCAN_WR  = 4'd3;
    localparam logic [3:0] S_P_POP    = 4'd4;
    localparam logic [3:0] S_P_RDL    = 4'd5;
    localparam logic [3:0] S_P_RDG    = 4'd6;
    localparam logic [3:0] S_P_UPD    = 4'd7;
    localparam logic [3:0] S_LG_POP   = 4'd8;
    localparam logic [3:0] S_LG_WR    = 4'd9;
    localparam logic [3:0] S_SM_POP   = 4'd10;
    localparam logic [3:0] S_SM_WR    = 4'd11;
    localparam logic [3:0] S_REPORT   = 4'd12;
    localparam logic [3:0] S_RD       = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sc_rsel = SC_SEL_SCAN;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_last) begin
                            o_cmd.scan_init = 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        o_cmd.rd_req = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = i_stat.scan_done ? S_P_POP : S_SCAN_MUL;
            end
            S_SCAN_MUL: begin
                o_cmd.scan_mul = 1'b1;
                n_state = S_SCAN_WR;
            end
            S_SCAN_WR: begin
                o_cmd.scan_wr = 1'b1;
                n_state = S_SCAN_RD;
            end
            S_P_POP: begin
                if (i_stat.sd_nz && i_stat.ld_nz) begin
                    o_cmd.pop_pair = 1'b1;
                    n_state = S_P_RDL;
                end else begin
                    n_state = S_LG_POP;
                end
            end
            S_P_RDL: begin
                o_cmd.cap_pair = 1'b1;
                o_cmd.sc_rsel  = SC_SEL_SMALL;
                n_state = S_P_RDG;
            end
            S_P_RDG: begin
                o_cmd.cap_sl  = 1'b1;
                o_cmd.sc_rsel = SC_SEL_G;
                n_state = S_P_UPD;
            end
            S_P_UPD: begin
                o_cmd.upd_pair = 1'b1;
                n_state = S_P_POP;
            end
            S_LG_POP: begin
                if (i_stat.ld_nz) begin
                    o_cmd.lg_pop = 1'b1;
                    n_state = S_LG_WR;
                end else begin
                    n_state = S_SM_POP;
                end
            end
            S_LG_WR: begin
                o_cmd.lg_wr = 1'b1;
                n_state = S_LG_POP;
            end
            S_SM_POP: begin
                if (i_stat.sd_nz) begin
                    o_cmd.sm_pop = 1'b1;
                    n_state = S_SM_WR;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_SM_WR: begin
                o_cmd.sm_wr = 1'b1;
                n_state = S_SM_POP;
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.rep_build = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.pr_rsel = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.rep_read = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/atb_datapath.sv @@
// atb_datapath: stores, stacks, counters, scaling multiplier and result register
// depends on atb_pkg and atb_ram
module atb_datapath #(
    parameter int MAX_BINS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  atb_pkg::t_cmd                i_cmd,
    output atb_pkg::t_stat               o_stat,
    input  logic [atb_pkg::MASS_W-1:0]   i_mass,
    input  logic [atb_pkg::INDEX_W-1:0]  i_index,
    output logic                         o_valid,
    input  logic                         i_out_ready,
    output logic [atb_pkg::OUT_DW-1:0]   o_data,
    output logic                         o_kind
);
    import atb_pkg::*;

    localparam int Aw = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int Cw = $clog2(MAX_BINS + 1);
    localparam int Sw = MASS_W + $clog2(MAX_BINS);
    localparam int Pw = MASS_W + Cw;
    localparam logic [Sw-1:0] ScOne  = Sw'(64'd1 << 32);
    localparam logic [Cw-1:0] CntMax = Cw'(MAX_BINS);

    // control state
    logic [Cw-1:0] r_cnt;
    logic          r_ovf;
    logic          r_ready;
    logic [Cw-1:0] r_i;
    logic [Cw-1:0] r_sd;
    logic [Cw-1:0] r_ld;
    logic          r_ovalid;

    // payload registers
    logic [Sw-1:0]      r_prod;
    logic [Aw-1:0]      r_l;
    logic [Aw-1:0]      r_g;
    logic [Sw-1:0]      r_sl;
    logic [INDEX_W-1:0] r_idx;
    logic [OUT_DW-1:0]  r_odata;
    logic               r_okind;

    // memory ports
    logic              sc_we;
    logic [Aw-1:0]     sc_waddr;
    logic [Sw-1:0]     sc_wdata;
    logic [Aw-1:0]     sc_raddr;
    logic [Sw-1:0]     sc_rdata;
    logic              pr_we;
    logic [Aw-1:0]     pr_waddr;
    logic [MASS_W-1:0] pr_wdata;
    logic [Aw-1:0]     al_wdata;
    logic [Aw-1:0]     pr_raddr;
    logic [MASS_W-1:0] pr_rdata;
    logic [Aw-1:0]     al_rdata;
    logic              sm_we;
    logic              lg_we;
    logic [Aw-1:0]     push_bin;
    logic [Aw-1:0]     sm_rdata;
    logic [Aw-1:0]     lg_rdata;
    logic [Cw-1:0]     sd_m1;
    logic [Cw-1:0]     ld_m1;

    // helpers
    logic [Cw-1:0]        cbase;
    logic                 room;
    logic [Pw-1:0]        prod;
    logic [Sw-1:0]        new_g;
    logic [Sw-1:0]        push_val;
    logic                 push_en;
    logic                 push_small;
    logic [Aw+INDEX_W-1:0] idx_wide;
    logic [INDEX_W-1:0]   idx_sel;
    logic                 idx_ok;
    logic [Cw+CNT_W-1:0]  cnt_wide;
    logic [CNT_W-1:0]     cnt_out;
    logic [Aw+INDEX_W-1:0] al_wide;
    logic [CNT_W-1:0]     rd_cnt;

    // load slot: a new set restarts at zero after a finished build
    assign cbase = r_ready ? '0 : r_cnt;
    assign room  = (cbase < CntMax);

    // scaling multiplier and pairing update
    assign prod  = Pw'(sc_rdata[MASS_W-1:0]) * Pw'(r_cnt);
    assign new_g = sc_rdata + r_sl - ScOne;

    // stack push shared by scan and pairing
    assign push_en    = i_cmd.scan_wr | i_cmd.upd_pair;
    assign push_val   = i_cmd.scan_wr ? r_prod : new_g;
    assign push_bin   = i_cmd.scan_wr ? r_i[Aw-1:0] : r_g;
    assign push_small = (push_val[Sw-1:32] == '0);
    assign sm_we      = push_en & push_small;
    assign lg_we      = push_en & ~push_small;
    assign sd_m1      = r_sd - 1'b1;
    assign ld_m1      = r_ld - 1'b1;

    // scaled store ports
    assign sc_we    = (i_cmd.load & room) | i_cmd.scan_wr | i_cmd.upd_pair;
    assign sc_waddr = i_cmd.load ? cbase[Aw-1:0] : (i_cmd.scan_wr ? r_i[Aw-1:0] : r_g);
    assign sc_wdata = i_cmd.load ? Sw'(i_mass) : (i_cmd.scan_wr ? r_prod : new_g);
    always_comb begin
        case (i_cmd.sc_rsel)
            SC_SEL_SMALL: sc_raddr = sm_rdata;
            SC_SEL_G:     sc_raddr = r_g;
            default:      sc_raddr = r_i[Aw-1:0];
        endcase
    end

    // probability and alias store ports
    assign pr_we    = i_cmd.upd_pair | i_cmd.lg_wr | i_cmd.sm_wr;
    assign pr_waddr = i_cmd.upd_pair ? r_l : (i_cmd.lg_wr ? lg_rdata : sm_rdata);
    assign pr_wdata = i_cmd.upd_pair ? r_sl[MASS_W-1:0] : PROB_ONE;
    assign al_wdata = i_cmd.upd_pair ? r_g : pr_waddr;
    assign idx_sel  = i_cmd.pr_rsel ? r_idx : i_index;
    assign idx_wide = {{Aw{1'b0}}, idx_sel};
    assign pr_raddr = idx_wide[Aw-1:0];

    // read checks and output sizing
    assign idx_ok   = r_ready && ({{Cw{1'b0}}, r_idx} < {{INDEX_W{1'b0}}, r_cnt});
    assign cnt_wide = {{CNT_W{1'b0}}, r_cnt};
    assign cnt_out  = cnt_wide[CNT_W-1:0];
    assign al_wide  = {{INDEX_W{1'b0}}, al_rdata};
    assign rd_cnt   = r_ready ? cnt_out : '0;

    atb_ram #(.WIDTH(Sw), .DEPTH(MAX_BINS)) u_scaled (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_waddr), .i_wdata(sc_wdata),
        .i_raddr(sc_raddr), .o_rdata(sc_rdata)
    );
    atb_ram #(.WIDTH(MASS_W), .DEPTH(MAX_BINS)) u_prob (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(pr_raddr), .o_rdata(pr_rdata)
    );
    atb_ram #(.WIDTH(Aw), .DEPTH(MAX_BINS)) u_alias (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(al_wdata),
        .i_raddr(pr_raddr), .o_rdata(al_rdata)
    );
    atb_ram #(.WIDTH(Aw), .DEPTH(MAX_BINS)) u_small (
        .i_clk(i_clk), .i_we(sm_we), .i_waddr(r_sd[Aw-1:0]), .i_wdata(push_bin),
        .i_raddr(sd_m1[Aw-1:0]), .o_rdata(sm_rdata)
    );
    atb_ram #(.WIDTH(Aw), .DEPTH(MAX_BINS)) u_large (
        .i_clk(i_clk), .i_we(lg_we), .i_waddr(r_ld[Aw-1:0]), .i_wdata(push_bin),
        .i_raddr(ld_m1[Aw-1:0]), .o_rdata(lg_rdata)
    );

    // counters, flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ready  <= 1'b0;
            r_i      <= '0;
            r_sd     <= '0;
            r_ld     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ready <= 1'b0;
                if (room) begin
                    r_cnt <= cbase + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.scan_init) begin
                r_i  <= '0;
                r_sd <= '0;
                r_ld <= '0;
            end
            if (i_cmd.scan_wr) begin
                r_i <= r_i + 1'b1;
            end
            if (sm_we) begin
                r_sd <= r_sd + 1'b1;
            end
            if (lg_we) begin
                r_ld <= r_ld + 1'b1;
            end
            if (i_cmd.pop_pair) begin
                r_sd <= sd_m1;
                r_ld <= ld_m1;
            end
            if (i_cmd.lg_pop) begin
                r_ld <= ld_m1;
            end
            if (i_cmd.sm_pop) begin
                r_sd <= sd_m1;
            end
            if (i_cmd.rep_build) begin
                r_ovf   <= 1'b0;
                r_ready <= 1'b1;
            end
            if (i_cmd.rep_build || i_cmd.rep_read) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_mul) begin
            r_prod <= prod[Sw-1:0];
        end
        if (i_cmd.cap_pair) begin
            r_l <= sm_rdata;
            r_g <= lg_rdata;
        end
        if (i_cmd.cap_sl) begin
            r_sl <= sc_rdata;
        end
        if (i_cmd.rd_req) begin
            r_idx <= i_index;
        end
        if (i_cmd.rep_build) begin
            r_okind <= KIND_REPORT;
            r_odata <= {r_ovf ? ERR_OVF : ERR_OK, cnt_out,
                        {INDEX_W{1'b0}}, {MASS_W{1'b0}}};
        end else if (i_cmd.rep_read) begin
            r_okind <= KIND_READ;
            if (idx_ok) begin
                r_odata <= {ERR_OK, cnt_out, al_wide[INDEX_W-1:0], pr_rdata};
            end else begin
                r_odata <= {ERR_BAD, rd_cnt, {INDEX_W{1'b0}}, {MASS_W{1'b0}}};
            end
        end
    end

    assign o_stat.scan_done = (r_i == r_cnt);
    assign o_stat.sd_nz     = (r_sd != '0);
    assign o_stat.ld_nz     = (r_ld != '0);
    assign o_stat.out_free  = ~r_ovalid | i_out_ready;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_kind  = r_okind;

`ifndef SYNTHESIS
    a_depths_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_sd} + {1'b0, r_ld}) <= {1'b0, r_cnt})
        else $error("stack depths exceed bin count");
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntMax)
        else $error("bin count beyond maximum");
    a_result_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rep_build || i_cmd.rep_read) |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten while full");
    a_build_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rep_build |=> (r_ready && r_ovalid))
        else $error("build report without table ready");
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.rd_req, i_cmd.scan_mul, i_cmd.scan_wr,
                  i_cmd.pop_pair, i_cmd.cap_pair, i_cmd.cap_sl, i_cmd.upd_pair,
                  i_cmd.lg_pop, i_cmd.lg_wr, i_cmd.sm_pop, i_cmd.sm_wr,
                  i_cmd.rep_build, i_cmd.rep_read}))
        else $error("more than one datapath step at once");
`endif

endmodule
